@@ rtl/hrlc_pkg.sv @@
`default_nettype none
package hrlc_pkg;

	// Parse phase, one-hot
	typedef enum logic [4:0] {
		PH_METHOD  = 5'b00001,
		PH_URI     = 5'b00010,
		PH_VERSION = 5'b00100,
		PH_HEADERS = 5'b01000,
		PH_SKIP    = 5'b10000
	} phase_t;

	// Dot tracking within one path segment
	localparam logic [1:0] SEG_START = 2'd0;
	localparam logic [1:0] SEG_ONE   = 2'd1;
	localparam logic [1:0] SEG_TWO   = 2'd2;
	localparam logic [1:0] SEG_OTHER = 2'd3;

	// Verdict codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD     = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	// Result kinds
	localparam logic KIND_URI     = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Characters
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_CTL   = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	localparam logic [31:0] CRLF_CRLF = 32'h0D0A0D0A;

	localparam logic [3:0] GET_LEN     = 4'd4;
	localparam logic [3:0] HEAD_LEN    = 4'd5;
	localparam logic [3:0] VER_LEN     = 4'd10;
	localparam logic [3:0] VER_MINOR_POS = 4'd7;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_request;
	} in_beat_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] uri_char;
		logic [1:0] status;
		logic       is_head;
		logic [7:0] path_len;
	} out_beat_t;

	typedef struct packed {
		phase_t      phase;
		logic [3:0]  match_pos;
		logic        head;
		logic        bad;
		logic        refused;
		logic [1:0]  seg_dots;
		logic [23:0] recent;
		logic        verdict_given;
	} parse_state_t;

	// Counter compares, worked out by the owner of the counters
	typedef struct packed {
		logic uri_zero;
		logic uri_full;
		logic uri_last;
		logic timeout;
	} cnt_flags_t;

	typedef struct packed {
		logic       active;
		logic       fire;
		logic       verdict;
		logic       uri_inc;
		logic [1:0] status;
	} step_t;

	localparam parse_state_t PARSE_CLEAR = '{
		phase: PH_METHOD, match_pos: 4'd0, head: 1'b0, bad: 1'b0, refused: 1'b0,
		seg_dots: SEG_START, recent: 24'd0, verdict_given: 1'b0};

	localparam parse_state_t PARSE_RESET = '{
		phase: PH_METHOD, match_pos: 4'd0, head: 1'b0, bad: 1'b0, refused: 1'b0,
		seg_dots: SEG_START, recent: 24'd0, verdict_given: 1'b1};

	function automatic logic [7:0] get_char(input logic [3:0] pos);
		case (pos)
			4'd0:    get_char = "G";
			4'd1:    get_char = "E";
			4'd2:    get_char = "T";
			4'd3:    get_char = " ";
			default: get_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] head_char(input logic [3:0] pos);
		case (pos)
			4'd0:    head_char = "H";
			4'd1:    head_char = "E";
			4'd2:    head_char = "A";
			4'd3:    head_char = "D";
			4'd4:    head_char = " ";
			default: head_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] ver_char(input logic [3:0] pos);
		case (pos)
			4'd0:    ver_char = "H";
			4'd1:    ver_char = "T";
			4'd2:    ver_char = "T";
			4'd3:    ver_char = "P";
			4'd4:    ver_char = "/";
			4'd5:    ver_char = "1";
			4'd6:    ver_char = ".";
			4'd7:    ver_char = "0";
			4'd8:    ver_char = 8'h0D;
			4'd9:    ver_char = 8'h0A;
			default: ver_char = 8'h00;
		endcase
	endfunction

endpackage
`default_nettype wire

@@ rtl/hrlc_in_if.sv @@
`default_nettype none
interface hrlc_in_if;
	import hrlc_pkg::*;

	logic     valid;
	logic     ready;
	in_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/hrlc_out_if.sv @@
`default_nettype none
interface hrlc_out_if;
	import hrlc_pkg::*;

	logic      valid;
	logic      ready;
	out_beat_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/http_request_line_checker_core.sv @@
`default_nettype none
// Byte-serial checker for an HTTP/1.x request line. Request bytes enter on req, one per
// beat; a beat with start_of_request set opens a new connection and is itself the first
// byte. The method must be "GET " or "HEAD " (else the verdict is method not allowed);
// each URI byte that is counted goes out on rsp as a URI beat (result_kind 0) as it is
// taken, then " HTTP/1.0" or " HTTP/1.1" and CRLF must follow. One verdict beat
// (result_kind 1) closes the request on the byte that completes the first CRLFCRLF, or
// as bad request on the byte that makes REQUEST_BYTES bytes without one; bytes that
// arrive before the first start or after a verdict are dropped without a result. The
// block takes one byte every clock cycle unless backpressure on rsp stalls it; the parse
// state is updated once per byte, and a result goes through the input register, then the
// result register, before it is offered on rsp. Backpressure on rsp stalls req only while
// both registers are full. A URI of PATH_BYTES-8 bytes or more is bad; bytes past that
// limit are not passed.
module http_request_line_checker_core #(
	parameter int REQUEST_BYTES = 1024,
	parameter int PATH_BYTES    = 256
) (
	input  wire          clk,
	input  wire          arst_n,
	hrlc_in_if.sink      req,
	hrlc_out_if.source   rsp
);
	import hrlc_pkg::*;

	localparam int URI_LIMIT = PATH_BYTES - 8;
	localparam int BW = $clog2(REQUEST_BYTES + 1);
	localparam int UW = $clog2(URI_LIMIT + 1);
	localparam logic [BW-1:0] REQ_C    = BW'(REQUEST_BYTES);
	localparam logic [UW-1:0] LIMIT_C  = UW'(URI_LIMIT);
	localparam logic [UW-1:0] LIMIT_M1 = UW'(URI_LIMIT - 1);

	// Input stage
	logic      valid_s1;
	in_beat_t  beat_s1;

	// Result register
	logic      out_valid_q;
	out_beat_t out_beat_q;

	// Parse state and counters
	parse_state_t  state_q;
	logic [BW-1:0] bytes_q;
	logic [UW-1:0] uri_q;

	parse_state_t  state_nxt;
	step_t         step;
	cnt_flags_t    flags;
	logic [BW-1:0] bytes_base;
	logic [BW-1:0] bytes_adv;
	logic [UW-1:0] uri_base;
	logic [UW-1:0] uri_nxt;
	logic [UW+7:0] uri_ext;
	logic          advance;
	logic          consume;
	out_beat_t     beat_nxt;

	// Advance when the result register is empty or being drained
	assign advance = !out_valid_q || rsp.ready;
	assign consume = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	// A start clears the counters before this byte is counted
	assign bytes_base = beat_s1.start_of_request ? '0 : bytes_q;
	assign uri_base   = beat_s1.start_of_request ? '0 : uri_q;
	assign bytes_adv  = bytes_base + BW'(bytes_base < REQ_C);

	assign flags.uri_zero = (uri_base == '0);
	assign flags.uri_full = (uri_base >= LIMIT_C);
	assign flags.uri_last = (uri_base >= LIMIT_M1);
	assign flags.timeout  = (bytes_adv >= REQ_C);

	hrlc_parse u_parse (
		.data_byte (beat_s1.data_byte),
		.start     (beat_s1.start_of_request),
		.cur       (state_q),
		.flags     (flags),
		.nxt       (state_nxt),
		.step      (step)
	);

	assign uri_nxt = uri_base + UW'(step.uri_inc);
	assign uri_ext = {8'd0, uri_nxt};

	// Build the result beat; a verdict wins over a URI byte on the same byte
	always_comb begin
		beat_nxt = '0;
		if (step.verdict) begin
			beat_nxt.result_kind = KIND_VERDICT;
			beat_nxt.status = step.status;
			if (step.status != ST_REFUSED) begin
				beat_nxt.is_head = state_nxt.head;
				beat_nxt.path_len = uri_ext[7:0];
			end
		end else begin
			beat_nxt.result_kind = KIND_URI;
			beat_nxt.uri_char = beat_s1.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			beat_s1 <= req.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_RESET;
			bytes_q <= '0;
			uri_q <= '0;
		end else if (consume) begin
			state_q <= state_nxt;
			if (step.active) begin
				bytes_q <= bytes_adv;
				uri_q <= uri_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= consume && step.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && step.fire) begin
			out_beat_q <= beat_nxt;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.payload = out_beat_q;

	// URI counter never passes the length limit
	a_uri_bound: assert property (@(posedge clk) disable iff (!arst_n)
		uri_q <= LIMIT_C)
		else $error("URI count above limit");

	// Byte counter saturates at the request size
	a_bytes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_q <= REQ_C)
		else $error("byte count above request size");

	// A URI beat comes only from a byte taken in the URI phase
	a_uri_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && step.fire && !step.verdict)
			|-> (state_q.phase == PH_URI && !beat_s1.start_of_request))
		else $error("URI beat outside URI phase");

	// After a verdict, bytes without a start give no result
	a_idle_after_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && state_q.verdict_given && !beat_s1.start_of_request) |-> !step.fire)
		else $error("result after verdict");
endmodule
`default_nettype wire

@@ rtl/hrlc_parse.sv @@
`default_nettype none
module hrlc_parse (
	input  logic [7:0]             data_byte,
	input  logic                   start,
	input  hrlc_pkg::parse_state_t cur,
	input  hrlc_pkg::cnt_flags_t   flags,
	output hrlc_pkg::parse_state_t nxt,
	output hrlc_pkg::step_t        step
);
	import hrlc_pkg::*;

	parse_state_t s;
	logic [31:0]  window;
	logic         ok;
	logic         emit;
	logic         crlf2;

	always_comb begin
		s = cur;
		if (start) begin
			s = PARSE_CLEAR;
		end
		nxt = s;
		step = '0;
		ok = 1'b0;
		emit = 1'b0;
		window = {s.recent, data_byte};
		crlf2 = (window == CRLF_CRLF);

		if (!s.verdict_given) begin
			step.active = 1'b1;
			nxt.recent = window[23:0];

			case (s.phase)
				PH_METHOD: begin
					if (s.match_pos == 4'd0) begin
						ok = (data_byte == CH_G) || (data_byte == CH_H);
						nxt.head = (data_byte == CH_H);
					end else if (s.head) begin
						ok = (s.match_pos < HEAD_LEN) && (data_byte == head_char(s.match_pos));
					end else begin
						ok = (s.match_pos < GET_LEN) && (data_byte == get_char(s.match_pos));
					end
					if (!ok) begin
						nxt.refused = 1'b1;
						nxt.head = 1'b0;
						nxt.phase = PH_SKIP;
					end else begin
						nxt.match_pos = s.match_pos + 4'd1;
						if (nxt.match_pos >= (nxt.head ? HEAD_LEN : GET_LEN)) begin
							nxt.phase = PH_URI;
							nxt.match_pos = 4'd0;
						end
					end
				end
				PH_URI: begin
					if (data_byte == CH_SP) begin
						if (flags.uri_zero || s.seg_dots == SEG_TWO) begin
							nxt.bad = 1'b1;
						end
						nxt.phase = PH_VERSION;
						nxt.match_pos = 4'd0;
					end else if (data_byte == CH_CR || data_byte == CH_LF) begin
						nxt.bad = 1'b1;
						nxt.phase = PH_SKIP;
					end else begin
						if (flags.uri_zero && data_byte != CH_SLASH) begin
							nxt.bad = 1'b1;
						end
						if (data_byte < CH_CTL || data_byte >= CH_DEL
								|| data_byte inside {8'h5C, 8'h25, 8'h3F, 8'h23}) begin
							nxt.bad = 1'b1;
						end
						if (data_byte == CH_SLASH) begin
							if (s.seg_dots == SEG_TWO) begin
								nxt.bad = 1'b1;
							end
							nxt.seg_dots = SEG_START;
						end else if (data_byte == CH_DOT) begin
							if (s.seg_dots == SEG_START) begin
								nxt.seg_dots = SEG_ONE;
							end else if (s.seg_dots == SEG_ONE) begin
								nxt.seg_dots = SEG_TWO;
							end else begin
								nxt.seg_dots = SEG_OTHER;
							end
						end else begin
							nxt.seg_dots = SEG_OTHER;
						end
						// Drop bytes past the length limit
						if (flags.uri_full) begin
							nxt.bad = 1'b1;
						end else begin
							emit = 1'b1;
							step.uri_inc = 1'b1;
							if (flags.uri_last) begin
								nxt.bad = 1'b1;
							end
						end
					end
				end
				PH_VERSION: begin
					if (s.match_pos == VER_MINOR_POS) begin
						ok = (data_byte == CH_ZERO) || (data_byte == CH_ONE);
					end else begin
						ok = (s.match_pos < VER_LEN) && (data_byte == ver_char(s.match_pos));
					end
					if (!ok) begin
						nxt.bad = 1'b1;
						nxt.phase = PH_SKIP;
					end else begin
						nxt.match_pos = s.match_pos + 4'd1;
						if (nxt.match_pos >= VER_LEN) begin
							nxt.phase = PH_HEADERS;
							nxt.match_pos = 4'd0;
						end
					end
				end
				default: begin
				end
			endcase

			if (crlf2 || flags.timeout) begin
				nxt.verdict_given = 1'b1;
				step.verdict = 1'b1;
				if (!crlf2) begin
					step.status = ST_BAD;
				end else if (nxt.refused || nxt.phase == PH_METHOD) begin
					step.status = ST_REFUSED;
				end else if (nxt.bad || nxt.phase != PH_HEADERS) begin
					step.status = ST_BAD;
				end else begin
					step.status = ST_OK;
				end
			end
			step.fire = step.verdict || emit;
		end
	end
endmodule
`default_nettype wire
